// ===== src/imhq_pkg.sv =====
// Shared types and constants for the indexed min-heap queue.
package imhq_pkg;
	localparam int DEF_MAX_ENTRIES = 64;
	localparam int DEF_KEY_BITS = 16;
	localparam int NODE_BITS = 6;
	localparam int NODE_COUNT = 64;
	localparam int FIELD_KEY_BITS = 16;
	localparam int COUNT_BITS = 7;

	typedef enum logic [1:0] {
		CMD_INSERT   = 2'd0,
		CMD_POP      = 2'd1,
		CMD_DECREASE = 2'd2,
		CMD_PEEK     = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_ABSENT = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0] command;
		logic [NODE_BITS-1:0] node_id;
		logic [FIELD_KEY_BITS-1:0] key;
	} cmd_item_t;

	typedef struct packed {
		logic [NODE_BITS-1:0] min_node_id;
		logic [FIELD_KEY_BITS-1:0] min_key;
		logic is_empty;
		logic [COUNT_BITS-1:0] entry_count;
		logic [1:0] status;
	} result_item_t;
endpackage

// ===== src/imhq_slot_mem.sv =====
// Heap slot memory: key and node id per slot, one write and one registered read per cycle.
module imhq_slot_mem #(
	parameter int DEPTH = 64,
	parameter int KEY_BITS = 16,
	parameter int ID_BITS = 6
) (
	input  logic clk,
	input  logic we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [KEY_BITS-1:0] wkey,
	input  logic [ID_BITS-1:0] wid,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [KEY_BITS-1:0] rkey,
	output logic [ID_BITS-1:0] rid
);
	logic [KEY_BITS+ID_BITS-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= {wkey, wid};
		end
		{rkey, rid} <= mem[raddr];
	end
endmodule

// ===== src/imhq_pos_mem.sv =====
// Node position map: heap slot per node, one write and one registered read per cycle.
module imhq_pos_mem #(
	parameter int SLOT_BITS = 6,
	parameter int NODES = 64
) (
	input  logic clk,
	input  logic we,
	input  logic [$clog2(NODES)-1:0] waddr,
	input  logic [SLOT_BITS-1:0] wdata,
	input  logic [$clog2(NODES)-1:0] raddr,
	output logic [SLOT_BITS-1:0] rdata
);
	logic [SLOT_BITS-1:0] mem [NODES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== src/indexed_min_heap_queue.sv =====
// Indexed min-heap queue top level: command sequencer over slot and position memories.
// Every command passes S_RD, S_FIN and S_DONE; errors and peeks do nothing more. An insert
// climbs from the new last slot, a smaller decrease-key from its own slot, a pop sinks from the root.
// Throughput: one transaction at a time; the sift walk sets it, busy holds until the strobe.
// Reset empties the queue, then clears every position map entry in S_CLR, busy high.
// The receiver cannot stall: each result shows for exactly one cycle with done high.
module indexed_min_heap_queue #(
	parameter int MAX_ENTRIES = imhq_pkg::DEF_MAX_ENTRIES,
	parameter int KEY_BITS = imhq_pkg::DEF_KEY_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  imhq_pkg::cmd_item_t cmd,
	output logic busy,
	output logic done,
	output imhq_pkg::result_item_t result
);
	import imhq_pkg::*;

	localparam int SB = $clog2(MAX_ENTRIES);
	localparam int CB = $clog2(MAX_ENTRIES + 1);

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_RD, S_LAST, S_DEC_RD, S_DEC_CMP, S_UP_RD, S_UP_CMP,
		S_DN_L, S_DN_R, S_DN_C, S_WB, S_FIN, S_DONE
	} state_t;

	state_t state_q;
	logic [NODE_BITS-1:0] clr_q;
	cmd_t op_q;
	logic [NODE_BITS-1:0] node_q;
	logic [KEY_BITS-1:0] key_q;
	logic [CB-1:0] count_q;
	status_t status_q;
	logic popped_q;
	logic [NODE_BITS-1:0] pop_id_q;
	logic [KEY_BITS-1:0] pop_key_q;
	// The item under sift: the hole it sits in, its key and id.
	logic [SB-1:0] cur_q;
	logic [KEY_BITS-1:0] ckey_q;
	logic [NODE_BITS-1:0] cid_q;
	// Best of item and left child during a sink step.
	logic [SB-1:0] oth_q;
	logic [KEY_BITS-1:0] okey_q;
	logic [NODE_BITS-1:0] oid_q;

	logic sm_we;
	logic [SB-1:0] sm_waddr, sm_raddr;
	logic [KEY_BITS-1:0] sm_wkey, sm_rkey;
	logic [NODE_BITS-1:0] sm_wid, sm_rid;
	logic pm_we;
	logic [NODE_BITS-1:0] pm_waddr, pm_raddr;
	// Position map entry: presence bit on top of the slot.
	logic [SB:0] pm_wdata, pm_rdata;

	imhq_slot_mem #(.DEPTH(MAX_ENTRIES), .KEY_BITS(KEY_BITS), .ID_BITS(NODE_BITS)) u_slot (
		.clk, .we(sm_we), .waddr(sm_waddr), .wkey(sm_wkey), .wid(sm_wid),
		.raddr(sm_raddr), .rkey(sm_rkey), .rid(sm_rid)
	);
	imhq_pos_mem #(.SLOT_BITS(SB + 1), .NODES(NODE_COUNT)) u_pos (
		.clk, .we(pm_we), .waddr(pm_waddr), .wdata(pm_wdata),
		.raddr(pm_raddr), .rdata(pm_rdata)
	);

	// Tree links of the hole; children carry two extra bits so they never wrap.
	logic [SB+1:0] lchild, rchild;
	logic [SB-1:0] parent;
	logic lvalid, rvalid;
	assign parent = (cur_q - SB'(1)) >> 1;
	assign lchild = {1'b0, cur_q, 1'b1};
	assign rchild = lchild + (SB+2)'(1);
	assign lvalid = lchild < (SB+2)'(count_q);
	assign rvalid = rchild < (SB+2)'(count_q);

	// Climb while strictly smaller than the parent now in the read port.
	logic up_move;
	assign up_move = (ckey_q < sm_rkey);

	// Sink: right child wins only when strictly smaller than the best so far.
	logic take_r, dn_move;
	logic [SB-1:0] best_slot;
	logic [KEY_BITS-1:0] best_key;
	logic [NODE_BITS-1:0] best_id;
	assign take_r = rvalid && (sm_rkey < okey_q);
	assign dn_move = take_r || (oth_q != cur_q);
	assign best_slot = take_r ? SB'(rchild) : oth_q;
	assign best_key = take_r ? sm_rkey : okey_q;
	assign best_id = take_r ? sm_rid : oid_q;

	assign busy = (state_q != S_IDLE);
	logic [KEY_BITS-1:0] in_key;
	assign in_key = KEY_BITS'(cmd.key);

	// Memory ports: one write to each memory per cycle; the read address is set in the state
	// just before the one that uses the registered data.
	always_comb begin
		sm_we = 1'b0;
		sm_waddr = cur_q;
		sm_wkey = ckey_q;
		sm_wid = cid_q;
		sm_raddr = '0;
		pm_we = 1'b0;
		pm_waddr = cid_q;
		pm_wdata = {1'b1, cur_q};
		pm_raddr = cmd.node_id;
		unique case (state_q)
			S_CLR: begin
				pm_we = 1'b1;
				pm_waddr = clr_q;
				pm_wdata = '0;
			end
			S_RD: begin
				// Fetch the last slot for a pop; drop the popped node from the map.
				sm_raddr = SB'(count_q - CB'(1));
				if (op_q == CMD_POP && count_q != '0) begin
					pm_we = 1'b1;
					pm_waddr = sm_rid;
					pm_wdata = '0;
				end
			end
			S_DEC_RD: sm_raddr = cur_q;
			S_UP_RD: sm_raddr = parent;
			S_UP_CMP: begin
				// Move the parent down into the hole.
				if (up_move) begin
					sm_we = 1'b1;
					sm_wkey = sm_rkey;
					sm_wid = sm_rid;
					pm_we = 1'b1;
					pm_waddr = sm_rid;
				end
			end
			S_DN_L: sm_raddr = SB'(lchild);
			S_DN_R: sm_raddr = SB'(rchild);
			S_DN_C: begin
				// Move the smaller child up into the hole.
				if (dn_move) begin
					sm_we = 1'b1;
					sm_wkey = best_key;
					sm_wid = best_id;
					pm_we = 1'b1;
					pm_waddr = best_id;
				end
			end
			S_WB: begin
				// Drop the sifted item into its final slot.
				sm_we = 1'b1;
				pm_we = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q <= '0;
			op_q <= CMD_INSERT;
			node_q <= '0;
			key_q <= '0;
			count_q <= '0;
			status_q <= ST_OK;
			popped_q <= 1'b0;
			pop_id_q <= '0;
			pop_key_q <= '0;
			cur_q <= '0;
			ckey_q <= '0;
			cid_q <= '0;
			oth_q <= '0;
			okey_q <= '0;
			oid_q <= '0;
			done <= 1'b0;
			result <= '0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_CLR: begin
					// Walk the position map once so every node reads as absent.
					clr_q <= clr_q + NODE_BITS'(1);
					if (clr_q == NODE_BITS'(NODE_COUNT - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (start) begin
						op_q <= cmd_t'(cmd.command);
						node_q <= cmd.node_id;
						key_q <= in_key;
						status_q <= ST_OK;
						popped_q <= 1'b0;
						state_q <= S_RD;
					end
				end
				S_RD: begin
					// Root in sm_r*, map entry of the node in pm_rdata.
					state_q <= S_FIN;
					unique case (op_q)
						CMD_INSERT: begin
							if (count_q >= CB'(MAX_ENTRIES)) begin
								status_q <= ST_FULL;
							end else if (pm_rdata[SB]) begin
								status_q <= ST_ABSENT;
							end else begin
								count_q <= count_q + CB'(1);
								cur_q <= SB'(count_q);
								ckey_q <= key_q;
								cid_q <= node_q;
								state_q <= (count_q != '0) ? S_UP_RD : S_WB;
							end
						end
						CMD_POP: begin
							if (count_q == '0) begin
								status_q <= ST_EMPTY;
							end else begin
								popped_q <= 1'b1;
								pop_id_q <= sm_rid;
								pop_key_q <= sm_rkey;
								count_q <= count_q - CB'(1);
								if (count_q != CB'(1)) state_q <= S_LAST;
							end
						end
						CMD_DECREASE: begin
							if (!pm_rdata[SB]) begin
								status_q <= ST_ABSENT;
							end else begin
								cur_q <= pm_rdata[SB-1:0];
								state_q <= S_DEC_RD;
							end
						end
						CMD_PEEK: begin
							if (count_q == '0) status_q <= ST_EMPTY;
						end
					endcase
				end
				S_LAST: begin
					// Last item becomes the root hole and sinks from there.
					ckey_q <= sm_rkey;
					cid_q <= sm_rid;
					cur_q <= '0;
					state_q <= S_DN_L;
				end
				S_DEC_RD: state_q <= S_DEC_CMP;
				S_DEC_CMP: begin
					// A key that is not smaller leaves the heap untouched.
					if (key_q < sm_rkey) begin
						ckey_q <= key_q;
						cid_q <= node_q;
						state_q <= (cur_q != '0) ? S_UP_RD : S_WB;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_UP_RD: state_q <= S_UP_CMP;
				S_UP_CMP: begin
					if (up_move) begin
						cur_q <= parent;
						state_q <= (parent != '0) ? S_UP_RD : S_WB;
					end else begin
						state_q <= S_WB;
					end
				end
				S_DN_L: state_q <= lvalid ? S_DN_R : S_WB;
				S_DN_R: begin
					// Left child data; the parent holds on a tie.
					if (sm_rkey < ckey_q) begin
						oth_q <= SB'(lchild);
						okey_q <= sm_rkey;
						oid_q <= sm_rid;
					end else begin
						oth_q <= cur_q;
						okey_q <= ckey_q;
						oid_q <= cid_q;
					end
					state_q <= S_DN_C;
				end
				S_DN_C: begin
					// Right child data; advance the hole or stop.
					if (dn_move) begin
						cur_q <= best_slot;
						state_q <= S_DN_L;
					end else begin
						state_q <= S_WB;
					end
				end
				S_WB: state_q <= S_FIN;
				S_FIN: state_q <= S_DONE;
				S_DONE: begin
					// Root read issued in S_FIN is in sm_r* now.
					done <= 1'b1;
					result.status <= status_q;
					result.entry_count <= COUNT_BITS'(count_q);
					result.is_empty <= (count_q == '0);
					result.min_node_id <= popped_q ? pop_id_q :
						(count_q == '0 ? '0 : sm_rid);
					result.min_key <= FIELD_KEY_BITS'(popped_q ? pop_key_q :
						(count_q == '0 ? '0 : sm_rkey));
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== verif/indexed_min_heap_queue_test.sv =====
// Self-checking test of the indexed min-heap queue: directed cases, then random command streams.
module indexed_min_heap_queue_test;
	import imhq_pkg::*;

	localparam int CAPACITY = DEF_MAX_ENTRIES;
	localparam int SETTLE_CYCLES = 40;

	logic clk;
	logic arst_n;
	logic start;
	cmd_item_t cmd;
	logic busy;
	logic done;
	result_item_t result;

	indexed_min_heap_queue DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.cmd(cmd),
		.busy(busy),
		.done(done),
		.result(result)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Shadow heap: slot contents, position map, presence bits and fill level.
	logic [FIELD_KEY_BITS-1:0] shadow_keys [CAPACITY];
	logic [NODE_BITS-1:0] shadow_ids [CAPACITY];
	int shadow_slot [NODE_COUNT];
	bit shadow_present [NODE_COUNT];
	int shadow_count;

	result_item_t expected_results [$];
	int mismatch_count;

	// Exchange two slots and keep the position map in step.
	function automatic void swap_heap_slots(int a, int b);
		logic [FIELD_KEY_BITS-1:0] k;
		logic [NODE_BITS-1:0] n;
		k = shadow_keys[a];
		n = shadow_ids[a];
		shadow_keys[a] = shadow_keys[b];
		shadow_ids[a] = shadow_ids[b];
		shadow_keys[b] = k;
		shadow_ids[b] = n;
		shadow_slot[shadow_ids[a]] = a;
		shadow_slot[shadow_ids[b]] = b;
	endfunction

	// Climb while strictly smaller than the parent.
	function automatic void sift_up(int s);
		int p;
		while (s > 0) begin
			p = (s - 1) / 2;
			if (shadow_keys[s] < shadow_keys[p]) begin
				swap_heap_slots(s, p);
				s = p;
			end else
				break;
		end
	endfunction

	// Sink toward the smallest child; the parent holds on ties, left wins over right.
	function automatic void sift_down(int s);
		int best;
		while (s < shadow_count) begin
			best = s;
			for (int c = 2 * s + 1; c <= 2 * s + 2; c++)
				if (c < shadow_count && shadow_keys[c] < shadow_keys[best])
					best = c;
			if (best == s)
				break;
			swap_heap_slots(s, best);
			s = best;
		end
	endfunction

	// Apply one command to the shadow heap and return the result it must produce.
	function automatic result_item_t predict_heap_result(cmd_item_t c);
		result_item_t r;
		status_t st;
		bit popped;
		int s;
		st = ST_OK;
		popped = 0;
		r = '0;
		case (cmd_t'(c.command))
			CMD_INSERT: begin
				if (shadow_count >= CAPACITY)
					st = ST_FULL;
				else if (shadow_present[c.node_id])
					st = ST_ABSENT;
				else begin
					s = shadow_count;
					shadow_keys[s] = c.key;
					shadow_ids[s] = c.node_id;
					shadow_slot[c.node_id] = s;
					shadow_present[c.node_id] = 1;
					shadow_count++;
					sift_up(s);
				end
			end
			CMD_POP: begin
				if (shadow_count == 0)
					st = ST_EMPTY;
				else begin
					r.min_node_id = shadow_ids[0];
					r.min_key = shadow_keys[0];
					popped = 1;
					shadow_present[shadow_ids[0]] = 0;
					shadow_count--;
					if (shadow_count > 0) begin
						shadow_keys[0] = shadow_keys[shadow_count];
						shadow_ids[0] = shadow_ids[shadow_count];
						shadow_slot[shadow_ids[0]] = 0;
						sift_down(0);
					end
				end
			end
			CMD_DECREASE: begin
				if (!shadow_present[c.node_id])
					st = ST_ABSENT;
				else begin
					s = shadow_slot[c.node_id];
					if (s < shadow_count && c.key < shadow_keys[s]) begin
						shadow_keys[s] = c.key;
						sift_up(s);
					end
				end
			end
			default: begin
				if (shadow_count == 0)
					st = ST_EMPTY;
			end
		endcase
		if (!popped && shadow_count > 0) begin
			r.min_node_id = shadow_ids[0];
			r.min_key = shadow_keys[0];
		end
		r.is_empty = (shadow_count == 0);
		r.entry_count = shadow_count[COUNT_BITS-1:0];
		r.status = st;
		return r;
	endfunction

	// Send one transaction after a random gap; predict it on acceptance.
	task automatic send_command(cmd_t op, logic [NODE_BITS-1:0] node,
			logic [FIELD_KEY_BITS-1:0] key);
		int gap;
		cmd_item_t c;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
		// Step past the previous acceptance edge, where start was just dropped.
		repeat (gap + 1) @(posedge clk);
		c.command = op;
		c.node_id = node;
		c.key = key;
		start <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		// Accepted at this edge: start was high and busy low.
		expected_results.push_back(predict_heap_result(c));
		start <= 1'b0;
	endtask

	// Hold the sender until every outstanding result has come back.
	task automatic drain_results();
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	// Compare each strobed result with the oldest prediction.
	always @(posedge clk) begin
		result_item_t e;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result: %p", result);
				mismatch_count++;
			end else begin
				e = expected_results.pop_front();
				if (result.min_node_id !== e.min_node_id) begin
					$error("min_node_id expected %0d actual %0d", e.min_node_id,
						result.min_node_id);
					mismatch_count++;
				end
				if (result.min_key !== e.min_key) begin
					$error("min_key expected %0d actual %0d", e.min_key, result.min_key);
					mismatch_count++;
				end
				if (result.is_empty !== e.is_empty) begin
					$error("is_empty expected %0d actual %0d", e.is_empty, result.is_empty);
					mismatch_count++;
				end
				if (result.entry_count !== e.entry_count) begin
					$error("entry_count expected %0d actual %0d", e.entry_count,
						result.entry_count);
					mismatch_count++;
				end
				if (result.status !== e.status) begin
					$error("status expected %0d actual %0d", e.status, result.status);
					mismatch_count++;
				end
			end
		end
	end

	// Pick a node that is (or is not) queued, falling back to any node.
	function automatic logic [NODE_BITS-1:0] pick_node(bit want_present);
		logic [NODE_BITS-1:0] n;
		for (int tries = 0; tries < 64; tries++) begin
			n = NODE_BITS'($urandom_range(0, NODE_COUNT - 1));
			if (shadow_present[n] == want_present)
				return n;
		end
		return n;
	endfunction

	// Errors on empty heap, extremes of key and node, ties, decrease special cases.
	task automatic test_directed();
		send_command(CMD_POP, 6'd0, 16'd0);
		send_command(CMD_PEEK, 6'd63, 16'hFFFF);
		send_command(CMD_DECREASE, 6'd5, 16'd1);
		send_command(CMD_INSERT, 6'd63, 16'hFFFF);
		send_command(CMD_INSERT, 6'd0, 16'hFFFF);
		send_command(CMD_INSERT, 6'd21, 16'hFFFF);
		send_command(CMD_INSERT, 6'd42, 16'h0000);
		send_command(CMD_INSERT, 6'd63, 16'd7);
		send_command(CMD_PEEK, 6'd0, 16'd0);
		send_command(CMD_DECREASE, 6'd21, 16'hFFFF);
		send_command(CMD_DECREASE, 6'd0, 16'h5555);
		send_command(CMD_DECREASE, 6'd63, 16'h0000);
		send_command(CMD_DECREASE, 6'd42, 16'h0000);
		send_command(CMD_POP, 6'd0, 16'd0);
		send_command(CMD_POP, 6'd0, 16'd0);
		send_command(CMD_POP, 6'd0, 16'd0);
		send_command(CMD_POP, 6'd0, 16'd0);
		send_command(CMD_POP, 6'd0, 16'd0);
		send_command(CMD_PEEK, 6'd0, 16'd0);
	endtask

	// Fill to capacity with all nodes, hit full, then pop everything out.
	task automatic test_full_heap();
		for (int n = 0; n < NODE_COUNT; n++)
			send_command(CMD_INSERT, n[NODE_BITS-1:0], 16'($urandom_range(0, 65535)));
		send_command(CMD_INSERT, 6'd17, 16'd3);
		send_command(CMD_INSERT, 6'd40, 16'hAAAA);
		send_command(CMD_DECREASE, pick_node(1'b1), 16'd0);
		for (int n = 0; n < NODE_COUNT + 1; n++)
			send_command(CMD_POP, 6'($urandom), 16'($urandom));
	endtask

	// Random streams biased toward valid commands, with narrow key ranges for ties.
	task automatic test_random_stream(int items);
		int sel;
		logic [FIELD_KEY_BITS-1:0] k;
		for (int i = 0; i < items; i++) begin
			if (i % 400 == 200)
				drain_results();
			sel = $urandom_range(0, 99);
			k = (i / 300) % 2 ? 16'($urandom_range(0, 7)) : 16'($urandom);
			if (sel < 40)
				send_command(CMD_INSERT, pick_node(sel < 4), k);
			else if (sel < 65)
				send_command(CMD_POP, 6'($urandom), 16'($urandom));
			else if (sel < 90)
				send_command(CMD_DECREASE, pick_node(sel < 87), k);
			else
				send_command(CMD_PEEK, 6'($urandom), 16'($urandom));
		end
	endtask

	initial begin
		start = 1'b0;
		cmd = '0;
		arst_n = 1'b0;
		mismatch_count = 0;
		shadow_count = 0;
		foreach (shadow_present[n]) begin
			shadow_present[n] = 0;
			shadow_slot[n] = 0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_heap();
		drain_results();
		test_random_stream(1480);
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Timeout for the slowest run of ~1650 items, with ample margin; it reports mismatches.
	initial begin
		#5000000;
		$display("Mismatches found");
		$finish;
	end
endmodule
